// ===== sv/mipq_pkg.sv =====
// package for the multilevel interrupt priority queue
// holds operation and status codes, the microcode rom and the
// sequencer/datapath control types; no dependencies
`default_nettype none

package mipq_pkg;

    localparam int LEVEL_W  = 3;
    localparam int STEP_W   = 5;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_CHECK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef logic [STEP_W-1:0] step_t;

    // program addresses
    localparam step_t S_DISPATCH  = 5'd0;
    localparam step_t S_ENQ_CHK   = 5'd1;
    localparam step_t S_ENQ_LOOP  = 5'd2;
    localparam step_t S_ENQ_CMP   = 5'd3;
    localparam step_t S_ENQ_SHIFT = 5'd4;
    localparam step_t S_ENQ_PUT   = 5'd5;
    localparam step_t S_DEQ_CHK   = 5'd6;
    localparam step_t S_DEQ_GRAB  = 5'd7;
    localparam step_t S_DEQ_LOOP  = 5'd8;
    localparam step_t S_DEQ_MOVE  = 5'd9;
    localparam step_t S_DEQ_END   = 5'd10;
    localparam step_t S_CHK       = 5'd11;
    localparam step_t S_PK_CHK    = 5'd12;
    localparam step_t S_PK_GRAB   = 5'd13;
    localparam step_t S_ERR_FULL  = 5'd14;
    localparam step_t S_ERR_EMPTY = 5'd15;
    localparam step_t S_DONE      = 5'd16;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD_K_N,
        ACT_READ_KM1,
        ACT_WRITE_OLD_DECK,
        ACT_WRITE_NEW_INC,
        ACT_READ_FRONT,
        ACT_GRAB,
        ACT_READ_KP1,
        ACT_WRITE_OLD_INCK,
        ACT_DEC_OCC,
        ACT_LOAD_HIGH,
        ACT_SET_FULL,
        ACT_SET_EMPTY,
        ACT_PUSH
    } act_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_DISPATCH,
        COND_ENQ_BAD,
        COND_RD_BAD,
        COND_K_ZERO,
        COND_PRIO_GE,
        COND_LAST,
        COND_NONE_PENDING
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ucode_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic enq_bad;
        logic rd_bad;
        logic k_zero;
        logic prio_ge;
        logic last;
        logic none_pending;
        logic out_free;
    } flags_t;

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        unique case (s)
            S_DISPATCH:  w = '{ACT_NONE,           COND_DISPATCH,     S_DISPATCH};
            S_ENQ_CHK:   w = '{ACT_LOAD_K_N,       COND_ENQ_BAD,      S_ERR_FULL};
            S_ENQ_LOOP:  w = '{ACT_READ_KM1,       COND_K_ZERO,       S_ENQ_PUT};
            S_ENQ_CMP:   w = '{ACT_NONE,           COND_PRIO_GE,      S_ENQ_PUT};
            S_ENQ_SHIFT: w = '{ACT_WRITE_OLD_DECK, COND_ALWAYS,       S_ENQ_LOOP};
            S_ENQ_PUT:   w = '{ACT_WRITE_NEW_INC,  COND_ALWAYS,       S_DONE};
            S_DEQ_CHK:   w = '{ACT_READ_FRONT,     COND_RD_BAD,       S_ERR_EMPTY};
            S_DEQ_GRAB:  w = '{ACT_GRAB,           COND_NEVER,        S_DISPATCH};
            S_DEQ_LOOP:  w = '{ACT_READ_KP1,       COND_LAST,         S_DEQ_END};
            S_DEQ_MOVE:  w = '{ACT_WRITE_OLD_INCK, COND_ALWAYS,       S_DEQ_LOOP};
            S_DEQ_END:   w = '{ACT_DEC_OCC,        COND_ALWAYS,       S_DONE};
            S_CHK:       w = '{ACT_LOAD_HIGH,      COND_NONE_PENDING, S_ERR_EMPTY};
            S_PK_CHK:    w = '{ACT_READ_FRONT,     COND_RD_BAD,       S_ERR_EMPTY};
            S_PK_GRAB:   w = '{ACT_GRAB,           COND_ALWAYS,       S_DONE};
            S_ERR_FULL:  w = '{ACT_SET_FULL,       COND_ALWAYS,       S_DONE};
            S_ERR_EMPTY: w = '{ACT_SET_EMPTY,      COND_NEVER,        S_DISPATCH};
            S_DONE:      w = '{ACT_PUSH,           COND_NEVER,        S_DISPATCH};
            default:     w = '{ACT_NONE,           COND_NEVER,        S_DISPATCH};
        endcase
        return w;
    endfunction

    function automatic step_t op_entry(input op_t op);
        step_t s;
        unique case (op)
            OP_ENQUEUE: s = S_ENQ_CHK;
            OP_DEQUEUE: s = S_DEQ_CHK;
            OP_PEEK:    s = S_PK_CHK;
            OP_CHECK:   s = S_CHK;
            default:    s = S_DONE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mipq_if.sv =====
// command and response channel interfaces for the priority queue
// depends on mipq_pkg for the operation and status types
`default_nettype none

interface mipq_cmd_if #(
    parameter int DATA_WIDTH     = 16,
    parameter int PRIORITY_WIDTH = 3
);
    import mipq_pkg::*;

    logic                      valid;
    logic                      ready;
    op_t                       operation;
    logic [LEVEL_W-1:0]        level;
    logic [DATA_WIDTH-1:0]     data_word;
    logic [PRIORITY_WIDTH-1:0] priority_req;

    modport source (output valid, operation, level, data_word, priority_req, input ready);
    modport sink   (input valid, operation, level, data_word, priority_req, output ready);
endinterface

interface mipq_rsp_if #(
    parameter int DATA_WIDTH = 16
);
    import mipq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] result_word;
    logic [LEVEL_W-1:0]    result_level;
    status_t               status;

    modport source (output valid, result_word, result_level, status, input ready);
    modport sink   (input valid, result_word, result_level, status, output ready);
endinterface

`default_nettype wire

// ===== sv/mipq_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module mipq_ram #(
    parameter int WIDTH  = 19,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/mipq_seq.sv =====
// microcode sequencer: step counter, control rom lookup, conditional jumps
// depends on mipq_pkg for the rom, control and flag types
`default_nettype none

module mipq_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire mipq_pkg::op_t    op,
    input  wire mipq_pkg::flags_t flags,
    output logic                  busy,
    output mipq_pkg::act_t        act
);
    import mipq_pkg::*;

    logic   busy_reg;
    logic   busy_next;
    step_t  step_reg;
    step_t  step_next;
    ucode_t uword;
    logic   taken;

    assign uword = ucode_rom(step_reg);

    always_comb
    begin
        unique case (uword.cond)
            COND_NEVER:        taken = 1'b0;
            COND_ALWAYS:       taken = 1'b1;
            COND_DISPATCH:     taken = 1'b1;
            COND_ENQ_BAD:      taken = flags.enq_bad;
            COND_RD_BAD:       taken = flags.rd_bad;
            COND_K_ZERO:       taken = flags.k_zero;
            COND_PRIO_GE:      taken = flags.prio_ge;
            COND_LAST:         taken = flags.last;
            COND_NONE_PENDING: taken = flags.none_pending;
            default:           taken = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = S_DISPATCH;
            end
        end
        else if (uword.act == ACT_PUSH)
        begin
            // hold on the last step until the output register frees up
            if (flags.out_free)
            begin
                busy_next = 1'b0;
            end
        end
        else if (uword.cond == COND_DISPATCH)
        begin
            step_next = op_entry(op);
        end
        else if (taken)
        begin
            step_next = uword.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= S_DISPATCH;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign busy = busy_reg;
    assign act  = busy_reg ? uword.act : ACT_NONE;

endmodule

`default_nettype wire

// ===== sv/multilevel_interrupt_priority_queue.sv =====
// enqueue moves the entries of lower priority back one slot and drops the new word
// into the hole; dequeue takes the front word and moves the rest forward one slot
// one command in flight, one entry ram access per step: a new command word is taken
// only after the response of the last one is loaded, and a waiting response holds
// the last step
// rst_n (async, active low) clears occupancy, sequencer and response valid, not the ram
`default_nettype none

module multilevel_interrupt_priority_queue #(
    parameter int LEVELS          = 8,
    parameter int DEPTH_PER_LEVEL = 8,
    parameter int DATA_WIDTH      = 16,
    parameter int PRIORITY_WIDTH  = 3
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mipq_cmd_if.sink    cmd,
    mipq_rsp_if.source  rsp
);
    import mipq_pkg::*;

    // level index, slot index and occupancy count widths
    localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SW  = (DEPTH_PER_LEVEL > 1) ? $clog2(DEPTH_PER_LEVEL) : 1;
    localparam int CW  = $clog2(DEPTH_PER_LEVEL + 1);
    localparam int LVW = (LW > LEVEL_W) ? LW : LEVEL_W;
    localparam int EW  = DATA_WIDTH + PRIORITY_WIDTH;
    localparam int AW  = LW + SW;

    // command registers
    op_t                       op_reg;
    logic [LVW-1:0]            lvl_reg;
    logic [DATA_WIDTH-1:0]     word_reg;
    logic [PRIORITY_WIDTH-1:0] prio_reg;
    logic [CW-1:0]             k_reg;

    // working result, copied to the response register at the end
    logic [DATA_WIDTH-1:0]     res_word_reg;
    logic [LEVEL_W-1:0]        res_level_reg;
    status_t                   res_status_reg;

    // response register
    logic                      rsp_valid_reg;
    logic [DATA_WIDTH-1:0]     rsp_word_reg;
    logic [LEVEL_W-1:0]        rsp_level_reg;
    status_t                   rsp_status_reg;

    // per-level entry counts
    logic [CW-1:0]             occ_reg [LEVELS];

    logic                      busy;
    act_t                      act;
    flags_t                    flags;
    logic                      accept;
    logic                      push;

    logic [LW-1:0]             lvl_idx;
    logic                      lvl_ok;
    logic [CW-1:0]             occ_cur;
    logic [CW-1:0]             km1;
    logic [CW:0]               kp1;
    logic [LW-1:0]             high_idx;
    logic                      none_pending;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [EW-1:0]             ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [EW-1:0]             ram_rdata;
    logic [DATA_WIDTH-1:0]     rd_word;
    logic [PRIORITY_WIDTH-1:0] rd_prio;

    assign accept = cmd.valid && cmd.ready;
    assign push   = (act == ACT_PUSH) && flags.out_free;

    assign lvl_idx = lvl_reg[LW-1:0];
    assign lvl_ok  = ({1'b0, lvl_reg} < (LVW + 1)'(LEVELS));
    assign occ_cur = occ_reg[lvl_idx];
    assign km1     = k_reg - 1'b1;
    assign kp1     = {1'b0, k_reg} + 1'b1;

    assign rd_word = ram_rdata[EW-1:PRIORITY_WIDTH];
    assign rd_prio = ram_rdata[PRIORITY_WIDTH-1:0];

    // highest level that holds anything
    always_comb
    begin
        high_idx     = '0;
        none_pending = 1'b1;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (occ_reg[i] != '0)
            begin
                high_idx     = LW'(i);
                none_pending = 1'b0;
            end
        end
    end

    always_comb
    begin
        flags.enq_bad      = !lvl_ok || (occ_cur == CW'(DEPTH_PER_LEVEL));
        flags.rd_bad       = !lvl_ok || (occ_cur == '0);
        flags.k_zero       = (k_reg == '0);
        flags.prio_ge      = (rd_prio >= prio_reg);
        flags.last         = (kp1 >= {1'b0, occ_cur});
        flags.none_pending = none_pending;
        flags.out_free     = !rsp_valid_reg || rsp.ready;
    end

    mipq_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .op    (op_reg),
        .flags (flags),
        .busy  (busy),
        .act   (act)
    );

    // entry ram ports: a read fetches a neighbor, a later write step moves it or
    // drops the new word into the hole
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = {lvl_idx, SW'(0)};
        ram_we    = 1'b0;
        ram_waddr = {lvl_idx, k_reg[SW-1:0]};
        ram_wdata = ram_rdata;
        case (act) inside
            ACT_READ_KM1:
            begin
                ram_re    = 1'b1;
                ram_raddr = {lvl_idx, km1[SW-1:0]};
            end
            ACT_READ_KP1:
            begin
                ram_re    = 1'b1;
                ram_raddr = {lvl_idx, kp1[SW-1:0]};
            end
            ACT_READ_FRONT:
            begin
                ram_re = 1'b1;
            end
            ACT_WRITE_OLD_DECK, ACT_WRITE_OLD_INCK:
            begin
                ram_we = 1'b1;
            end
            ACT_WRITE_NEW_INC:
            begin
                ram_we    = 1'b1;
                ram_wdata = {word_reg, prio_reg};
            end
            default:
            begin
            end
        endcase
    end

    mipq_ram #(
        .WIDTH  (EW),
        .ADDR_W (AW)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // command and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= cmd.operation;
            lvl_reg        <= LVW'(cmd.level);
            word_reg       <= cmd.data_word;
            prio_reg       <= cmd.priority_req;
            res_word_reg   <= '0;
            res_level_reg  <= '0;
            res_status_reg <= ST_OK;
        end
        else
        begin
            case (act)
                ACT_LOAD_K_N:       k_reg <= occ_cur;
                ACT_WRITE_OLD_DECK: k_reg <= km1;
                ACT_READ_FRONT:     k_reg <= '0;
                ACT_WRITE_OLD_INCK: k_reg <= kp1[CW-1:0];
                ACT_GRAB:
                begin
                    res_word_reg  <= rd_word;
                    // only a check reports the level it found
                    res_level_reg <= (op_reg == OP_CHECK) ? lvl_reg[LEVEL_W-1:0] : '0;
                end
                ACT_LOAD_HIGH:      lvl_reg <= LVW'(high_idx);
                ACT_SET_FULL:       res_status_reg <= ST_FULL;
                ACT_SET_EMPTY:      res_status_reg <= ST_EMPTY;
                default:
                begin
                end
            endcase
        end
    end

    // occupancy counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                occ_reg[i] <= '0;
            end
        end
        else if (act == ACT_WRITE_NEW_INC)
        begin
            occ_reg[lvl_idx] <= occ_cur + 1'b1;
        end
        else if (act == ACT_DEC_OCC)
        begin
            occ_reg[lvl_idx] <= occ_cur - 1'b1;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rsp_word_reg   <= res_word_reg;
            rsp_level_reg  <= res_level_reg;
            rsp_status_reg <= res_status_reg;
        end
    end

    assign cmd.ready        = !busy;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_word  = rsp_word_reg;
    assign rsp.result_level = rsp_level_reg;
    assign rsp.status       = rsp_status_reg;

`ifndef SYNTH
    // a level never counts past its depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy && lvl_ok |-> occ_cur <= CW'(DEPTH_PER_LEVEL))
        else $error("level occupancy beyond depth");

    // the entry ram is only written for a command on a real level
    a_write_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> busy && lvl_ok)
        else $error("entry write outside a command");

    // a full status only comes from an enqueue
    a_full_is_enq: assert property (@(posedge clk) disable iff (!rst_n)
        push && res_status_reg == ST_FULL |-> op_reg == OP_ENQUEUE)
        else $error("full status on a non-enqueue");

    // only a check reports a nonzero level
    a_level_check: assert property (@(posedge clk) disable iff (!rst_n)
        push && op_reg != OP_CHECK |-> res_level_reg == '0)
        else $error("result level set outside a check");

    // the response register is loaded only after the command is accepted
    a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !cmd.ready)
        else $error("response pushed while idle");
`endif

endmodule

`default_nettype wire
